// ----- hw/rtl/ffha_pkg.sv -----
// Shared types, codes and defaults for the first-fit heap allocator.
package ffha_pkg;

    // Default sizing of the heap and of the block table.
    localparam int HEAP_BYTES_DEF   = 262144;
    localparam int HEADER_BYTES_DEF = 12;
    localparam int MAX_BLOCKS_DEF   = 1024;

    // Internal byte-count width; covers the largest heap plus a rounded request.
    localparam int ACC_W = 21;

    // Request operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FAIL    = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    typedef struct packed {
        logic        op;
        logic [18:0] req_size;
        logic [17:0] block_addr;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [17:0] payload_addr;
        logic [18:0] granted_size;
    } res_t;

    // One entry of the block table.
    typedef struct packed {
        logic [ACC_W-1:0] size;
        logic             free;
    } entry_t;

endpackage

// ----- hw/rtl/first_fit_heap_allocator.sv -----
// Top level of the first-fit heap allocator: sequencer, state and result register.
//
// Requests arrive on req_valid/req_stall/req_data, one at a time. An allocate
// walks the block table one entry per cycle looking for the first free block
// that is large enough; if none fits it appends a block at the heap end, or
// fails when the table is full or the heap has no room. A free walks the
// table to find the block, marks it free, then makes a second pass over the
// table that merges runs of free blocks, one entry per cycle; a free of an
// unknown block is ignored. The next request can be accepted in the cycle
// after the result is taken. The table memory port, read once per cycle, and
// the single span adder set the scan rate.
// Exactly one result per request appears on res_valid/res_stall/res_data and
// is held in an output register until taken. req_stall stays high while a
// request is in progress or a result is still waiting, so a stalled receiver
// simply holds off further requests.
// Reset empties the table and the heap; no clearing pass is needed because
// only entries below the block count are ever read.
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
    parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  ffha_pkg::req_t req_data,
    output logic           res_valid,
    input  logic           res_stall,
    output ffha_pkg::res_t res_data
);
    import ffha_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    localparam logic [ACC_W-1:0] HDR  = ACC_W'(HEADER_BYTES);
    localparam logic [ACC_W-1:0] HEAP = ACC_W'(HEAP_BYTES);
    localparam logic [CNT_W-1:0] MAXB = CNT_W'(MAX_BLOCKS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_APPEND = 3'd2;
    localparam logic [2:0] S_MSTART = 3'd3;
    localparam logic [2:0] S_MERGE  = 3'd4;
    localparam logic [2:0] S_FLUSH  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic             op_reg, op_next;
    logic [ACC_W-1:0] wanted_reg, wanted_next;
    logic [17:0]      addr_reg, addr_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [ACC_W-1:0] start_reg, start_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ACC_W-1:0] heap_end_reg, heap_end_next;
    logic [CNT_W-1:0] w_reg, w_next;
    entry_t           prev_reg, prev_next;
    res_t             res_reg, res_next;
    logic             res_valid_reg, res_valid_next;

    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
    entry_t           rdata;

    logic [ACC_W-1:0] span_acc;
    logic [ACC_W-1:0] span_size;
    logic [ACC_W-1:0] span_sum;

    logic             last;
    logic [ACC_W-1:0] req_min;
    logic [ACC_W-1:0] req_rnd;
    logic [ACC_W-1:0] hdr_start;
    logic [ACC_W-1:0] hdr_heap;

    ffha_table #(
        .DEPTH (MAX_BLOCKS),
        .IDX_W (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    ffha_span #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_span (
        .acc  (span_acc),
        .size (span_size),
        .sum  (span_sum)
    );

    // Operand selection for the shared span adder.
    always_comb
    begin
        case (state_reg)
            S_APPEND:
            begin
                span_acc  = heap_end_reg;
                span_size = wanted_reg;
            end
            S_MERGE:
            begin
                span_acc  = prev_reg.size;
                span_size = rdata.size;
            end
            default:
            begin
                span_acc  = start_reg;
                span_size = rdata.size;
            end
        endcase
    end

    // Helpers for the sequencer.
    assign last      = (CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg;
    assign req_min   = (req_data.req_size == 19'd0) ? ACC_W'(1)
                                                    : ACC_W'(req_data.req_size);
    assign req_rnd   = (req_min + ACC_W'(3)) & ~ACC_W'(3);
    assign hdr_start = start_reg + HDR;
    assign hdr_heap  = heap_end_reg + HDR;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        wanted_next    = wanted_reg;
        addr_next      = addr_reg;
        idx_next       = idx_reg;
        start_next     = start_reg;
        cnt_next       = cnt_reg;
        heap_end_next  = heap_end_reg;
        w_next         = w_reg;
        prev_next      = prev_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        we             = 1'b0;
        waddr          = idx_reg;
        wdata          = rdata;
        raddr          = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && !req_stall)
                begin
                    op_next     = req_data.op;
                    wanted_next = req_rnd;
                    addr_next   = req_data.block_addr;
                    idx_next    = '0;
                    start_next  = '0;
                    raddr       = '0;
                    if (cnt_reg != '0)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (req_data.op == OP_ALLOC)
                    begin
                        state_next = S_APPEND;
                    end
                    else
                    begin
                        res_next       = '{status: ST_IGNORED, payload_addr: '0,
                                           granted_size: '0};
                        res_valid_next = 1'b1;
                    end
                end
            end

            S_SCAN:
            begin
                if (op_reg == OP_ALLOC && rdata.free && rdata.size >= wanted_reg)
                begin
                    // First fit found: hand out the whole block.
                    we             = 1'b1;
                    wdata          = '{size: rdata.size, free: 1'b0};
                    res_next       = '{status: ST_DONE, payload_addr: hdr_start[17:0],
                                       granted_size: rdata.size[18:0]};
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (op_reg == OP_FREE && hdr_start == ACC_W'(addr_reg))
                begin
                    we         = 1'b1;
                    wdata      = '{size: rdata.size, free: 1'b1};
                    state_next = S_MSTART;
                end
                else
                begin
                    start_next = span_sum;
                    if (last)
                    begin
                        if (op_reg == OP_ALLOC)
                        begin
                            state_next = S_APPEND;
                        end
                        else
                        begin
                            res_next       = '{status: ST_IGNORED, payload_addr: '0,
                                               granted_size: '0};
                            res_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        raddr    = idx_reg + IDX_W'(1);
                    end
                end
            end

            S_APPEND:
            begin
                // New block at the heap end, if the table and the heap allow it.
                if (cnt_reg < MAXB && span_sum <= HEAP)
                begin
                    we            = 1'b1;
                    waddr         = cnt_reg[IDX_W-1:0];
                    wdata         = '{size: wanted_reg, free: 1'b0};
                    cnt_next      = cnt_reg + CNT_W'(1);
                    heap_end_next = span_sum;
                    res_next      = '{status: ST_DONE, payload_addr: hdr_heap[17:0],
                                      granted_size: wanted_reg[18:0]};
                end
                else
                begin
                    res_next = '{status: ST_FAIL, payload_addr: '0, granted_size: '0};
                end
                res_valid_next = 1'b1;
                state_next     = S_IDLE;
            end

            S_MSTART:
            begin
                raddr      = '0;
                idx_next   = '0;
                w_next     = '0;
                state_next = S_MERGE;
            end

            S_MERGE:
            begin
                // Fold a free entry into a free predecessor, else compact it down.
                if (w_reg != '0 && prev_reg.free && rdata.free)
                begin
                    prev_next.size = span_sum;
                end
                else
                begin
                    if (w_reg != '0)
                    begin
                        we    = 1'b1;
                        waddr = IDX_W'(w_reg - CNT_W'(1));
                        wdata = prev_reg;
                    end
                    prev_next = rdata;
                    w_next    = w_reg + CNT_W'(1);
                end
                if (last)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    raddr    = idx_reg + IDX_W'(1);
                end
            end

            S_FLUSH:
            begin
                we             = 1'b1;
                waddr          = IDX_W'(w_reg - CNT_W'(1));
                wdata          = prev_reg;
                cnt_next       = w_reg;
                res_next       = '{status: ST_DONE, payload_addr: '0, granted_size: '0};
                res_valid_next = 1'b1;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            heap_end_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            heap_end_reg  <= heap_end_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Working registers and result payload.
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        wanted_reg <= wanted_next;
        addr_reg   <= addr_next;
        idx_reg    <= idx_next;
        start_reg  <= start_next;
        w_reg      <= w_next;
        prev_reg   <= prev_next;
        res_reg    <= res_next;
    end

    assign req_stall = (state_reg != S_IDLE) || res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // Checks.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !req_stall |-> !res_valid)
        else $error("request accepted while a result is pending");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAXB)
        else $error("block count exceeds table depth");

    a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        heap_end_reg <= HEAP)
        else $error("heap end beyond heap");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.status != ST_DONE
            |-> res_data.payload_addr == '0 && res_data.granted_size == '0)
        else $error("failed result carries a grant");

endmodule

// ----- hw/rtl/ffha_table.sv -----
// Block table memory: one write port and one registered read port.
module ffha_table #(
    parameter int DEPTH = 1024,
    parameter int IDX_W = 10
) (
    input  logic                clk,
    input  logic                we,
    input  logic [IDX_W-1:0]    waddr,
    input  ffha_pkg::entry_t    wdata,
    input  logic [IDX_W-1:0]    raddr,
    output ffha_pkg::entry_t    rdata
);
    import ffha_pkg::*;

    entry_t mem [DEPTH];

    // Write first in program order; a read of the same address returns old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/ffha_span.sv -----
// Shared span adder: accumulator plus a block's header and size, rounded to four.
module ffha_span #(
    parameter int HEADER_BYTES = 12
) (
    input  logic [ffha_pkg::ACC_W-1:0] acc,
    input  logic [ffha_pkg::ACC_W-1:0] size,
    output logic [ffha_pkg::ACC_W-1:0] sum
);
    import ffha_pkg::*;

    localparam logic [ACC_W-1:0] HDR_RND = ACC_W'(HEADER_BYTES + 3);

    logic [ACC_W-1:0] raw;
    logic [ACC_W-1:0] span;

    // Round header plus size up to a multiple of four, then add.
    assign raw  = size + HDR_RND;
    assign span = {raw[ACC_W-1:2], 2'b00};
    assign sum  = acc + span;

endmodule
